// ----- rtl/mrdi_pkg.sv -----
// Shared types and constants for the discrete-input read responder.
// No dependencies; every other file imports this package.
package mrdi_pkg;

    // Function code answered by this block
    localparam logic [7:0] FC_READ_DI    = 8'h02;
    localparam logic [7:0] EXC_FLAG      = 8'h80;
    // Largest quantity a single request may ask for
    localparam int         MAX_READ_BITS = 2000;
    // APB address width: two 32-bit registers at byte offsets 0 and 4
    localparam int         APB_ADDR_W    = 3;

    typedef enum logic [7:0] {
        EXC_NONE             = 8'd0,
        EXC_ILLEGAL_FUNCTION = 8'd1,
        EXC_ILLEGAL_ADDRESS  = 8'd2,
        EXC_ILLEGAL_VALUE    = 8'd3
    } t_exc;

    typedef enum logic {
        REG_OWN_ADDRESS   = 1'b0,
        REG_INPUTS_IN_USE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        op;
        logic [7:0]  input_index;
        logic        input_value;
        logic [7:0]  slave_addr;
        logic [7:0]  function_code;
        logic [15:0] start_addr;
        logic [15:0] quantity;
    } t_req;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic       last;
    } t_rsp;

    typedef struct packed {
        logic [7:0] own_address;
        logic [8:0] inputs_in_use;
    } t_cfg;

    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic       value;
    } t_bank_wr;

endpackage

// ----- rtl/mrdi_req_if.sv -----
// Request channel: valid/ready handshake carrying one t_req.
// Depends on mrdi_pkg.
interface mrdi_req_if import mrdi_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mrdi_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one response byte.
// Depends on mrdi_pkg.
interface mrdi_rsp_if import mrdi_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mrdi_cfg.sv -----
// APB register file: own slave address and number of inputs in use.
// Depends on mrdi_pkg.
module mrdi_cfg import mrdi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [7:0] r_own_address;
    logic [8:0] r_inputs_in_use;
    t_reg_idx   reg_idx;
    logic       wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Update the addressed register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= 8'd1;
            r_inputs_in_use <= 9'd256;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OWN_ADDRESS:   r_own_address   <= pwdata[7:0];
                REG_INPUTS_IN_USE: r_inputs_in_use <= pwdata[8:0];
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_OWN_ADDRESS:   prdata = {24'd0, r_own_address};
            REG_INPUTS_IN_USE: prdata = {23'd0, r_inputs_in_use};
        endcase
    end

    assign o_cfg.own_address   = r_own_address;
    assign o_cfg.inputs_in_use = r_inputs_in_use;

endmodule

// ----- rtl/mrdi_bank.sv -----
// Discrete-input store: byte-wide rows, one bit written and one row read per cycle.
// Row valid flags make never-written rows read as zero right after reset.
// Depends on mrdi_pkg.
module mrdi_bank import mrdi_pkg::*; #(
    parameter int INPUT_CAPACITY = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_bank_wr             i_wr,
    input  logic                 i_rd_en,
    input  logic [$clog2((INPUT_CAPACITY+7)/8+1)-1:0] i_rd_row,
    output logic [7:0]           o_rd_data
);

    localparam int ROWS  = (INPUT_CAPACITY + 7) / 8;
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RA_W  = $clog2(ROWS + 1);

    logic [7:0]      r_mem [ROWS];
    logic [ROWS-1:0] r_row_valid;
    logic [7:0]      r_rd_data;
    logic            r_rd_ok;

    logic [15:0]      wr_row_ext;
    logic [IDX_W-1:0] wr_row;
    logic [2:0]       wr_bit;
    logic             wr_ok;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_hit;

    assign wr_row_ext = {8'd0, i_wr.index} >> 3;
    assign wr_row     = wr_row_ext[IDX_W-1:0];
    assign wr_bit     = i_wr.index[2:0];
    assign wr_ok      = i_wr.en && (32'(i_wr.index) < 32'(INPUT_CAPACITY));
    assign rd_idx     = i_rd_row[IDX_W-1:0];
    assign rd_hit     = i_rd_en && (i_rd_row < RA_W'(ROWS));

    // Mark rows as written; reset drops every row back to zero at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_row_valid[wr_row] <= 1'b1;
            end
            r_rd_ok <= rd_hit && r_row_valid[rd_idx];
        end
    end

    // Write one bit, or seed a fresh row around it; read one row
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            if (r_row_valid[wr_row]) begin
                r_mem[wr_row][wr_bit] <= i_wr.value;
            end else begin
                r_mem[wr_row] <= 8'({7'd0, i_wr.value}) << wr_bit;
            end
        end
        if (rd_hit) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : 8'd0;

endmodule

// ----- rtl/mrdi_seq.sv -----
// Request sequencer: decodes a request, emits header bytes and then packs
// data bytes through one funnel shifter fed a row at a time from the bank.
// Depends on mrdi_pkg, mrdi_req_if, mrdi_rsp_if.
module mrdi_seq import mrdi_pkg::*; #(
    parameter int INPUT_CAPACITY = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mrdi_req_if.sink     i_req,
    mrdi_rsp_if.source   o_rsp,
    input  t_cfg         i_cfg,
    output t_bank_wr     o_wr,
    output logic         o_rd_en,
    output logic [$clog2((INPUT_CAPACITY+7)/8+1)-1:0] o_rd_row,
    input  logic [7:0]   i_rd_data
);

    localparam int ROWS = (INPUT_CAPACITY + 7) / 8;
    localparam int RA_W = $clog2(ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD0,
        S_HEAD1,
        S_HEAD2,
        S_DATA
    } t_state;

    t_state          r_state;
    t_req            r_req;
    t_exc            r_code;
    logic [RA_W-1:0] r_row;
    logic [7:0]      r_left;
    logic            r_pend;
    logic [15:0]     r_win;
    logic            r_out_valid;
    t_rsp            r_out;

    logic        accept;
    logic        out_free;
    logic        foreign;
    logic [16:0] limit;
    logic [16:0] span_end;
    logic [16:0] count_ext;
    logic [15:0] start_row;
    t_exc        dec_code;
    logic        is_exc;
    logic [15:0] shifted;
    logic [7:0]  pad_mask;
    logic [7:0]  data_byte;
    logic        issue;
    logic        load;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Bit writes go straight to the bank on acceptance
    assign o_wr.en    = accept && !i_req.data.op;
    assign o_wr.index = i_req.data.input_index;
    assign o_wr.value = i_req.data.input_value;

    // Decode checks on the held request
    assign foreign   = (r_req.slave_addr != i_cfg.own_address) && (r_req.slave_addr != 8'd0);
    assign limit     = (17'(i_cfg.inputs_in_use) > 17'(INPUT_CAPACITY))
                     ? 17'(INPUT_CAPACITY) : 17'(i_cfg.inputs_in_use);
    assign span_end  = {1'b0, r_req.start_addr} + {1'b0, r_req.quantity};
    assign count_ext = ({1'b0, r_req.quantity} + 17'd7) >> 3;
    assign start_row = r_req.start_addr >> 3;

    always_comb begin
        priority if (r_req.function_code != FC_READ_DI) begin
            dec_code = EXC_ILLEGAL_FUNCTION;
        end else if (r_req.quantity == 16'd0 || r_req.quantity > 16'(MAX_READ_BITS)) begin
            dec_code = EXC_ILLEGAL_VALUE;
        end else if (span_end > limit) begin
            dec_code = EXC_ILLEGAL_ADDRESS;
        end else begin
            dec_code = EXC_NONE;
        end
    end

    assign is_exc = (r_code != EXC_NONE);

    // Funnel shift the two-row window down to the current bit offset
    assign shifted   = r_win >> r_req.start_addr[2:0];
    assign pad_mask  = (r_left == 8'd1 && r_req.quantity[2:0] != 3'd0)
                     ? ((8'd1 << r_req.quantity[2:0]) - 8'd1) : 8'hFF;
    assign data_byte = shifted[7:0] & pad_mask;

    // Fetch two rows during the header, then one row per data byte but the last
    always_comb begin
        unique case (r_state)
            S_HEAD0, S_HEAD1: issue = out_free && !is_exc;
            S_DATA:           issue = out_free && !r_pend && (r_left > 8'd1);
            default:          issue = 1'b0;
        endcase
    end

    // Load the output register with the next response byte
    always_comb begin
        unique case (r_state)
            S_HEAD0, S_HEAD1, S_HEAD2: load = out_free;
            S_DATA:                    load = out_free && !r_pend;
            default:                   load = 1'b0;
        endcase
    end

    assign o_rd_en  = issue;
    assign o_rd_row = r_row;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_pend <= issue;
            if (r_pend) begin
                r_win <= {i_rd_data, r_win[15:8]};
            end
            if (issue) begin
                r_row <= r_row + RA_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_req.data.op) begin
                        r_req   <= i_req.data;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_code  <= dec_code;
                    r_left  <= count_ext[7:0];
                    r_row   <= start_row[RA_W-1:0];
                    r_state <= foreign ? S_IDLE : S_HEAD0;
                end
                S_HEAD0: begin
                    if (out_free) begin
                        r_out.resp_byte <= r_req.slave_addr;
                        r_out.last      <= 1'b0;
                        r_state         <= S_HEAD1;
                    end
                end
                S_HEAD1: begin
                    if (out_free) begin
                        r_out.resp_byte <= is_exc ? (r_req.function_code | EXC_FLAG)
                                                  : r_req.function_code;
                        r_out.last      <= 1'b0;
                        r_state         <= S_HEAD2;
                    end
                end
                S_HEAD2: begin
                    if (out_free) begin
                        r_out.resp_byte <= is_exc ? r_code : r_left;
                        r_out.last      <= is_exc;
                        r_state         <= is_exc ? S_IDLE : S_DATA;
                    end
                end
                S_DATA: begin
                    if (out_free && !r_pend) begin
                        r_out.resp_byte <= data_byte;
                        r_out.last      <= (r_left == 8'd1);
                        r_left          <= r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

// ----- rtl/modbus_read_discrete_inputs_responder.sv -----
// Operation: a bit write reaches the store on acceptance; a request passes a decode state,
// then three header bytes at one per cycle while the response side takes them, and data
// bytes, each loaded after its row read and funnel shift, never while a read is pending.
// Throughput: one request at a time; response stalls hold it up, and no request or bit write
// is accepted until the sequencer is idle again after the last byte (after decode if foreign).
// Reset: synchronous active low; resets sequencer, registers and row flags (store reads zero).
module modbus_read_discrete_inputs_responder import mrdi_pkg::*; #(
    parameter int INPUT_CAPACITY = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mrdi_req_if.sink              i_req,
    mrdi_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int RA_W = $clog2((INPUT_CAPACITY + 7) / 8 + 1);

    t_cfg            cfg;
    t_bank_wr        bank_wr;
    logic            rd_en;
    logic [RA_W-1:0] rd_row;
    logic [7:0]      rd_data;

    // Configuration registers
    mrdi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Discrete-input store
    mrdi_bank #(.INPUT_CAPACITY(INPUT_CAPACITY)) u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (bank_wr),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    // Request sequencer
    mrdi_seq #(.INPUT_CAPACITY(INPUT_CAPACITY)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_cfg     (cfg),
        .o_wr      (bank_wr),
        .o_rd_en   (rd_en),
        .o_rd_row  (rd_row),
        .i_rd_data (rd_data)
    );

endmodule
